// ----- design/assert_macros.svh -----
// Assertion macros shared by the glyph renderer modules.
// No dependencies; included by every file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on the rising edge, suspended while reset is asserted.
`define BFGR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BFGR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/bfgr_pkg.sv -----
// Shared constants, codes and types of the bitmap font glyph renderer.
// No dependencies; imported by every module of the block except bfgr_ram.
package bfgr_pkg;

	localparam int GLYPH_STORE_BYTES = 16384;
	localparam int CODE_POINTS       = 65536;
	localparam int MAX_HEIGHT        = 32;
	localparam int MAX_WIDTH         = 32;

	localparam int STORE_AW = $clog2(GLYPH_STORE_BYTES);
	localparam int CP_AW    = $clog2(CODE_POINTS);
	localparam int BYTE_W   = 8;
	localparam int MAP_W    = 9;
	localparam int GEOM_W   = 6;
	localparam int MAX_RB   = (MAX_WIDTH + 7) / 8;
	localparam int RB_W     = $clog2(MAX_RB + 1);
	localparam int POS_W    = (MAX_RB > 1) ? $clog2(MAX_RB) : 1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QP_W        = $clog2(QUEUE_DEPTH);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;
	localparam int IN_DATA_W  = 136;
	localparam int OUT_DATA_W = 128;

	localparam logic [CFG_IDX_W-1:0] REG_SCANLINE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GCOUNT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GBYTES   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GHEIGHT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GWIDTH   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_EN   = 3'd5;

	localparam logic [1:0] MODE_STORE = 2'd0;
	localparam logic [1:0] MODE_MAP   = 2'd1;
	localparam logic [1:0] MODE_DRAW  = 2'd2;

	localparam logic [1:0] K_NONE  = 2'd0;
	localparam logic [1:0] K_STORE = 2'd1;
	localparam logic [1:0] K_MAP   = 2'd2;
	localparam logic [1:0] K_DRAW  = 2'd3;

	typedef struct packed {
		logic [13:0] scanline_pixels;
		logic [9:0]  glyph_count;
		logic [7:0]  glyph_bytes;
		logic [5:0]  glyph_height;
		logic [5:0]  glyph_width;
		logic        map_enable;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] addr;
		logic [8:0]  data;
		logic [15:0] chr;
		logic [11:0] col;
		logic [11:0] row;
		logic [31:0] fg;
		logic [31:0] bg;
	} item_t;

endpackage

// ----- design/bfgr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instanced for the glyph store and the code map.
module bfgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/bfgr_front.sv -----
// Input side: accepts stream requests, classifies them and forwards to the queue.
// Depends on bfgr_pkg.
module bfgr_front import bfgr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// bits 15:0 load_address, 24:16 load_data, 40:25 character, 52:41 cell_column,
	// 64:53 cell_row, 96:65 foreground, 128:97 background, 135:129 zero
	input  logic [IN_DATA_W-1:0] s_axis_tdata,
	// bits 1:0 mode
	input  logic [1:0]           s_axis_tuser,
	input  logic                 clearing,
	input  logic                 q_full,
	output logic                 push,
	output item_t                push_item
);

	logic  vld_s1;
	item_t ent_s1;
	item_t in_item;
	logic  accept;
	logic  fwd;

	always_comb begin
		in_item.addr = s_axis_tdata[15:0];
		in_item.data = s_axis_tdata[24:16];
		in_item.chr  = s_axis_tdata[40:25];
		in_item.col  = s_axis_tdata[52:41];
		in_item.row  = s_axis_tdata[64:53];
		in_item.fg   = s_axis_tdata[96:65];
		in_item.bg   = s_axis_tdata[128:97];
		case (s_axis_tuser)
			MODE_STORE: in_item.kind = (32'(s_axis_tdata[15:0]) < GLYPH_STORE_BYTES) ?
				K_STORE : K_NONE;
			MODE_MAP:   in_item.kind = (32'(s_axis_tdata[15:0]) < CODE_POINTS) ?
				K_MAP : K_NONE;
			MODE_DRAW:  in_item.kind = K_DRAW;
			default:    in_item.kind = K_NONE;
		endcase
	end

	assign fwd           = vld_s1 & ((ent_s1.kind == K_NONE) | ~q_full);
	assign s_axis_tready = ~clearing & (~vld_s1 | fwd);
	assign accept        = s_axis_tvalid & s_axis_tready;
	assign push          = vld_s1 & (ent_s1.kind != K_NONE) & ~q_full;
	assign push_item     = ent_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (fwd) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_s1 <= in_item;
		end
	end

endmodule

// ----- design/bfgr_queue.sv -----
// Short request queue between the classifying front and the executing back.
// Depends on bfgr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bfgr_queue import bfgr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output item_t head,
	output logic  empty
);

	item_t         ent_q [QUEUE_DEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QP_W:0]   cnt_q;

	assign full  = (cnt_q == (QP_W+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

	`BFGR_ASSERT(a_queue_no_overflow, clk, arst_n, push |-> !full, "push into full queue")
	`BFGR_ASSERT(a_queue_no_underflow, clk, arst_n, pop |-> !empty, "pop from empty queue")
	`BFGR_ASSERT(a_queue_count_bound, clk, arst_n, cnt_q <= (QP_W+1)'(QUEUE_DEPTH), "queue count out of range")

endmodule

// ----- design/bfgr_back.sv -----
// Execution side: glyph store and code map, draw sequencer, row assembly, output stage.
// Depends on bfgr_pkg, bfgr_ram and assert_macros.svh.
`include "assert_macros.svh"
module bfgr_back import bfgr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  item_t                 head,
	input  logic                  q_empty,
	output logic                  q_pop,
	output logic                  clearing,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// bits 31:0 row_offset, 63:32 row_pattern, 95:64 fill_colour, 127:96 back_colour
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_GLYPH = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_OFFS  = 3'd4;
	localparam logic [2:0] S_ROWS  = 3'd5;

	logic [2:0]        state_q;
	logic [CP_AW-1:0]  clr_q;

	logic [15:0]       chr_q;
	logic [11:0]       col_q;
	logic [11:0]       row_q;
	logic [31:0]       fg_q;
	logic [31:0]       bg_q;
	logic [9:0]        glyph_q;
	logic [17:0]       rh_q;
	logic [17:0]       cw_q;
	logic [31:0]       rhl_q;
	logic [31:0]       row_off_q;

	logic [STORE_AW-1:0] iss_addr_q;
	logic [RB_W-1:0]     iss_b_q;
	logic [GEOM_W-1:0]   iss_y_q;
	logic                iss_done_q;

	logic              cap_vld_s1;
	logic [POS_W-1:0]  tag_pos_s1;
	logic              tag_end_s1;
	logic              tag_last_s1;
	logic [31:0]       pat_q;

	logic              out_vld_q;
	logic [31:0]       out_off_q;
	logic [31:0]       out_pat_q;
	logic [31:0]       out_fill_q;
	logic [31:0]       out_back_q;
	logic              out_last_q;

	logic [GEOM_W-1:0] h_sat;
	logic [GEOM_W-1:0] w_sat;
	logic [GEOM_W:0]   w_plus;
	logic [RB_W-1:0]   rb;
	logic [RB_W-1:0]   rb_eff;
	logic [31:0]       pat_mask;
	logic [15:0]       line_bytes;
	logic [15:0]       g_sel;
	logic              g_ok;
	logic [17:0]       base_prod;
	logic [33:0]       rhl_prod;

	logic              stall;
	logic              consume;
	logic              issue;
	logic              out_load;
	logic              row_end_iss;
	logic [31:0]       pat_byte;
	logic [31:0]       pat_next;

	logic              glyph_we;
	logic [BYTE_W-1:0] glyph_rdata;
	logic              map_we;
	logic [CP_AW-1:0]  map_waddr;
	logic [MAP_W-1:0]  map_wdata;
	logic              map_re;
	logic [MAP_W-1:0]  map_rdata;

	assign clearing = (state_q == S_CLEAR);

	assign h_sat      = (cfg.glyph_height > GEOM_W'(MAX_HEIGHT)) ? GEOM_W'(MAX_HEIGHT)
		: cfg.glyph_height;
	assign w_sat      = (cfg.glyph_width > GEOM_W'(MAX_WIDTH)) ? GEOM_W'(MAX_WIDTH)
		: cfg.glyph_width;
	assign w_plus     = {1'b0, w_sat} + (GEOM_W+1)'(7);
	assign rb         = RB_W'(w_plus >> 3);
	assign rb_eff     = (rb == '0) ? RB_W'(1) : rb;
	assign pat_mask   = ~(32'hFFFF_FFFF >> w_sat);
	assign line_bytes = {cfg.scanline_pixels, 2'b00};

	always_comb begin
		if (cfg.map_enable) begin
			g_sel = (32'(chr_q) < CODE_POINTS) ? 16'(map_rdata) : 16'd0;
		end else begin
			g_sel = chr_q;
		end
	end
	assign g_ok = (g_sel != 16'd0) && (g_sel < 16'(cfg.glyph_count));

	assign base_prod = 18'(glyph_q) * 18'(cfg.glyph_bytes);
	assign rhl_prod  = 34'(rh_q) * 34'(line_bytes);

	assign q_pop = (state_q == S_IDLE) & ~q_empty;

	assign stall       = cap_vld_s1 & tag_end_s1 & out_vld_q & ~m_axis_tready;
	assign consume     = cap_vld_s1 & ~stall;
	assign out_load    = consume & tag_end_s1;
	assign issue       = (state_q == S_ROWS) & ~iss_done_q & ~stall;
	assign row_end_iss = (iss_b_q == rb_eff - 1'b1);

	assign pat_byte = {glyph_rdata, 24'd0} >> {tag_pos_s1, 3'b000};
	assign pat_next = ((tag_pos_s1 == '0) ? 32'd0 : pat_q) | pat_byte;

	assign glyph_we  = q_pop & (head.kind == K_STORE);
	assign map_we    = clearing | (q_pop & (head.kind == K_MAP));
	assign map_waddr = clearing ? clr_q : head.addr[CP_AW-1:0];
	assign map_wdata = clearing ? '0 : head.data;
	assign map_re    = q_pop & (head.kind == K_DRAW);

	bfgr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(GLYPH_STORE_BYTES)
	) u_glyph_ram (
		.clk  (clk),
		.we   (glyph_we),
		.waddr(head.addr[STORE_AW-1:0]),
		.wdata(head.data[BYTE_W-1:0]),
		.re   (issue),
		.raddr(iss_addr_q),
		.rdata(glyph_rdata)
	);

	bfgr_ram #(
		.WIDTH(MAP_W),
		.DEPTH(CODE_POINTS)
	) u_map_ram (
		.clk  (clk),
		.we   (map_we),
		.waddr(map_waddr),
		.wdata(map_wdata),
		.re   (map_re),
		.raddr(head.chr[CP_AW-1:0]),
		.rdata(map_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			iss_b_q    <= '0;
			iss_y_q    <= '0;
			iss_done_q <= 1'b0;
			cap_vld_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CP_AW'(CODE_POINTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_pop && head.kind == K_DRAW) begin
						state_q <= S_GLYPH;
					end
				end
				S_GLYPH: state_q <= S_MUL;
				S_MUL:   state_q <= S_OFFS;
				S_OFFS: begin
					iss_b_q    <= '0;
					iss_y_q    <= '0;
					iss_done_q <= 1'b0;
					state_q    <= (h_sat == '0) ? S_IDLE : S_ROWS;
				end
				S_ROWS: begin
					if (issue) begin
						if (row_end_iss) begin
							iss_b_q <= '0;
							if (iss_y_q == h_sat - 1'b1) begin
								iss_done_q <= 1'b1;
							end else begin
								iss_y_q <= iss_y_q + 1'b1;
							end
						end else begin
							iss_b_q <= iss_b_q + 1'b1;
						end
					end
					if (consume && tag_last_s1) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (issue) begin
				cap_vld_s1 <= 1'b1;
			end else if (consume) begin
				cap_vld_s1 <= 1'b0;
			end

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && head.kind == K_DRAW) begin
			chr_q <= head.chr;
			col_q <= head.col;
			row_q <= head.row;
			fg_q  <= head.fg;
			bg_q  <= head.bg;
		end
		if (state_q == S_GLYPH) begin
			glyph_q <= g_ok ? g_sel[9:0] : 10'd0;
			rh_q    <= 18'(row_q) * 18'(h_sat);
			cw_q    <= 18'(col_q) * 18'(w_sat);
		end
		if (state_q == S_MUL) begin
			iss_addr_q <= base_prod[STORE_AW-1:0];
			rhl_q      <= rhl_prod[31:0];
		end
		if (state_q == S_OFFS) begin
			row_off_q <= rhl_q + 32'({cw_q, 2'b00});
		end else if (out_load) begin
			row_off_q <= row_off_q + 32'(line_bytes);
		end
		if (issue) begin
			iss_addr_q  <= iss_addr_q + 1'b1;
			tag_pos_s1  <= iss_b_q[POS_W-1:0];
			tag_end_s1  <= row_end_iss;
			tag_last_s1 <= row_end_iss & (iss_y_q == h_sat - 1'b1);
		end
		if (consume) begin
			pat_q <= pat_next;
		end
		if (out_load) begin
			out_off_q  <= row_off_q;
			out_pat_q  <= pat_next & pat_mask;
			out_fill_q <= fg_q;
			out_back_q <= bg_q;
			out_last_q <= tag_last_s1;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_back_q, out_fill_q, out_pat_q, out_off_q};
	assign m_axis_tlast  = out_last_q;

	`BFGR_ASSERT(a_back_load_free, clk, arst_n,
		out_load |-> (!out_vld_q || m_axis_tready), "row loaded over unsent result")
	`BFGR_ASSERT(a_back_stall_hold, clk, arst_n,
		stall |=> cap_vld_s1 && $stable(tag_pos_s1), "stalled row byte lost")
	`BFGR_ASSERT(a_back_clear_quiet, clk, arst_n,
		clearing |-> !q_pop && !cap_vld_s1 && !out_vld_q, "activity during map clear")

endmodule

// ----- design/bitmap_font_glyph_renderer_core.sv -----
// Top level of the bitmap font glyph renderer: configuration registers and wiring.
// Depends on bfgr_pkg, bfgr_front, bfgr_queue and bfgr_back.
// A request is registered in the front stage and then pushed into the queue; loads are
// written as they are popped. A draw steps through the S_GLYPH, S_MUL and S_OFFS setup states,
// then reads ceil(width/8) glyph bytes per row (at least one) for height rows, each row being
// assembled into the output register. Reset clears control state, then a code map clearing pass
// holds s_axis_tready low; configuration writes are taken throughout.
module bitmap_font_glyph_renderer_core import bfgr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// bits 15:0 load_address, 24:16 load_data, 40:25 character, 52:41 cell_column,
	// 64:53 cell_row, 96:65 foreground, 128:97 background, 135:129 zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// bits 1:0 mode
	input  logic [1:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// bits 31:0 row_offset, 63:32 row_pattern, 95:64 fill_colour, 127:96 back_colour
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t  cfg_q;
	logic  clearing;
	logic  push;
	item_t push_item;
	logic  q_full;
	logic  q_pop;
	item_t head;
	logic  q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scanline_pixels <= 14'd1024;
			cfg_q.glyph_count     <= 10'd256;
			cfg_q.glyph_bytes     <= 8'd16;
			cfg_q.glyph_height    <= 6'd16;
			cfg_q.glyph_width     <= 6'd8;
			cfg_q.map_enable      <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCANLINE: cfg_q.scanline_pixels <= cfg_data;
				REG_GCOUNT:   cfg_q.glyph_count     <= cfg_data[9:0];
				REG_GBYTES:   cfg_q.glyph_bytes     <= cfg_data[7:0];
				REG_GHEIGHT:  cfg_q.glyph_height    <= cfg_data[5:0];
				REG_GWIDTH:   cfg_q.glyph_width     <= cfg_data[5:0];
				REG_MAP_EN:   cfg_q.map_enable      <= cfg_data[0];
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	bfgr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.clearing     (clearing),
		.q_full       (q_full),
		.push         (push),
		.push_item    (push_item)
	);

	bfgr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (q_full),
		.pop      (q_pop),
		.head     (head),
		.empty    (q_empty)
	);

	bfgr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.clearing     (clearing),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule
